FILE: sv/lph_pkg.sv
// shared constants and controller/datapath interface types for the length-position histogram
package lph_pkg;

	localparam int unsigned MAX_LEN_DEF = 100;
	localparam int unsigned MAX_POS_DEF = 4096;

	localparam int unsigned SEQ_W   = 8;
	localparam int unsigned POS_W_F = 13;
	localparam int unsigned BLEN_W  = 7;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned TL_W    = 13;
	// wide enough for any position limit, up to 65536
	localparam int unsigned CMP_W   = 17;

	localparam logic [TL_W-1:0] TL_RESET = 13'd4096;

	localparam logic REQ_RECORD  = 1'b0;
	localparam logic REQ_READOUT = 1'b1;

	typedef struct packed {
		logic clear_en;
		logic accept;
		logic update;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ctl_sts_t;

endpackage

FILE: sv/lph_ram.sv
// generic single-write, single-read ram with registered read data
module lph_ram #(
	parameter int unsigned WIDTH = lph_pkg::CNT_W,
	parameter int unsigned DEPTH = lph_pkg::MAX_LEN_DEF * lph_pkg::MAX_POS_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/lph_ctrl.sv
// controller state machine: clearing sweep, request accept, update step
module lph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lph_pkg::ctl_sts_t sts,
	output lph_pkg::ctl_cmd_t cmd,
	output logic              busy
);
	import lph_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.clear_en = (state_q == ST_CLEAR);
	assign cmd.accept   = (state_q == ST_IDLE) && start;
	assign cmd.update   = (state_q == ST_UPDATE);
	assign busy         = (state_q != ST_IDLE);

	a_update_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.accept))
		else $error("update step without a preceding accept");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> busy && !cmd.accept)
		else $error("request accepted while previous one still in work");

endmodule

FILE: sv/lph_dp.sv
// datapath: config register, kept length, bin address, counter ram, saturating update
module lph_dp #(
	parameter int unsigned MAX_LEN       = lph_pkg::MAX_LEN_DEF,
	parameter int unsigned MAX_POSITIONS = lph_pkg::MAX_POS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lph_pkg::ctl_cmd_t           cmd,
	output lph_pkg::ctl_sts_t           sts,
	input  logic                        req_type,
	input  logic                        is_mapped,
	input  logic                        on_target,
	input  logic                        has_sequence,
	input  logic [lph_pkg::SEQ_W-1:0]   seq_length,
	input  logic [lph_pkg::POS_W_F-1:0] map_position,
	input  logic [lph_pkg::BLEN_W-1:0]  bin_length,
	input  logic [lph_pkg::POS_W_F-1:0] bin_position,
	input  logic                        cfg_write,
	input  logic [lph_pkg::TL_W-1:0]    cfg_data,
	output logic                        done,
	output logic [lph_pkg::CNT_W-1:0]   bin_count
);
	import lph_pkg::*;

	localparam int unsigned LEN_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned POS_W     = $clog2(MAX_POSITIONS);
	localparam int unsigned RAM_DEPTH = MAX_LEN * (2 ** POS_W);
	localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

	localparam logic [CMP_W-1:0]  MAX_POS_C = CMP_W'(MAX_POSITIONS);
	localparam logic [8:0]        MAX_LEN_C = 9'(MAX_LEN);
	localparam logic [LEN_W-1:0]  TOP_LEN   = LEN_W'(MAX_LEN - 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RAM_DEPTH - 1);

	logic [TL_W-1:0]   tl_q;
	logic [LEN_W-1:0]  kept_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              req_q;
	logic              wr_ok_q;
	logic              rd_ok_q;
	logic [ADDR_W-1:0] addr_q;
	logic              done_q;
	logic [CNT_W-1:0]  bin_count_q;

	logic [CMP_W-1:0]  eff_len;
	logic [8:0]        slen9;
	logic [LEN_W-1:0]  clamp_idx;
	logic              set_len;
	logic [LEN_W-1:0]  rec_len_idx;
	logic              rec_ok;
	logic              rd_ok;
	logic [ADDR_W-1:0] rec_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] acc_addr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	logic [CNT_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  sat_inc;

	// effective position limit is the smaller of register and table size
	assign eff_len = (CMP_W'(tl_q) > MAX_POS_C) ? MAX_POS_C : CMP_W'(tl_q);

	// length clamp to 1..MAX_LEN, held as length minus one
	assign slen9 = {1'b0, seq_length};
	always_comb begin
		if (seq_length == '0) begin
			clamp_idx = '0;
		end else if (slen9 > MAX_LEN_C) begin
			clamp_idx = TOP_LEN;
		end else begin
			clamp_idx = LEN_W'(slen9 - 9'd1);
		end
	end

	assign set_len     = (req_type == REQ_RECORD) && is_mapped && has_sequence;
	assign rec_len_idx = set_len ? clamp_idx : kept_q;

	assign rec_ok = (req_type == REQ_RECORD) && is_mapped && on_target
		&& (map_position != '0) && (CMP_W'(map_position) <= eff_len);
	assign rd_ok = (bin_length != '0) && (9'(bin_length) <= MAX_LEN_C)
		&& (bin_position != '0) && (CMP_W'(bin_position) <= eff_len);

	assign rec_addr = ADDR_W'({rec_len_idx, POS_W'(map_position - 13'd1)});
	assign rd_addr  = ADDR_W'({LEN_W'(bin_length - 7'd1), POS_W'(bin_position - 13'd1)});
	assign acc_addr = (req_type == REQ_READOUT) ? rd_addr : rec_addr;

	assign sat_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
	assign ram_we    = cmd.clear_en || (cmd.update && wr_ok_q);
	assign ram_waddr = cmd.clear_en ? clr_addr_q : addr_q;
	assign ram_wdata = cmd.clear_en ? '0 : sat_inc;

	lph_ram #(
		.WIDTH (CNT_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (acc_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q       <= TL_RESET;
			kept_q     <= '0;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				tl_q <= cfg_data;
			end
			if (cmd.accept && set_len) begin
				kept_q <= clamp_idx;
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			done_q <= cmd.update && (req_q == REQ_READOUT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= req_type;
			wr_ok_q <= rec_ok;
			rd_ok_q <= rd_ok;
			addr_q  <= acc_addr;
		end
		if (cmd.update) begin
			bin_count_q <= rd_ok_q ? ram_rdata : '0;
		end
	end

	assign sts.clear_last = (clr_addr_q == LAST_ADDR);
	assign done           = done_q;
	assign bin_count      = bin_count_q;

	a_done_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.update) && $past(req_q == REQ_READOUT))
		else $error("result strobe without a readout update");

	a_write_only_record: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !cmd.clear_en) |-> (cmd.update && req_q == REQ_RECORD))
		else $error("counter write outside a record update");

	a_kept_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= TOP_LEN)
		else $error("kept length beyond table rows");

endmodule

FILE: sv/length_position_histogram_unit.sv
// top level of the read length by position histogram
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  request   | start / busy              | req_type, is_mapped, on_target,
//            |                           | has_sequence, seq_length, map_position,
//            |                           | bin_length, bin_position
//  result    | done (one-cycle strobe)   | bin_count
//  config    | cfg_valid / cfg_ready     | transcript_length
//
// a request is taken on a clock edge with start high and busy low
// every request is handled in two steps: the counter ram is read when it is
// accepted, then the bumped count is written back or the readout register loaded
// in the update step, with busy high; the counter ram has a single read/write port pair
// a readout's result shows in the cycle after its update step: done is high for
// one cycle only and bin_count holds until the next update; the receiver has no way to hold it
// after reset the ram is swept to zero, all MAX_LEN * 2**clog2(MAX_POSITIONS)
// words (409600 at defaults), with busy high; config writes are taken any time
module length_position_histogram_unit #(
	parameter int unsigned MAX_LEN       = lph_pkg::MAX_LEN_DEF,
	parameter int unsigned MAX_POSITIONS = lph_pkg::MAX_POS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic                        is_mapped,
	input  logic                        on_target,
	input  logic                        has_sequence,
	input  logic [lph_pkg::SEQ_W-1:0]   seq_length,
	input  logic [lph_pkg::POS_W_F-1:0] map_position,
	input  logic [lph_pkg::BLEN_W-1:0]  bin_length,
	input  logic [lph_pkg::POS_W_F-1:0] bin_position,
	// result channel
	output logic                        done,
	output logic [lph_pkg::CNT_W-1:0]   bin_count,
	// config channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lph_pkg::TL_W-1:0]    transcript_length
);
	import lph_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// the register is a plain flop, so a write is always taken
	assign cfg_ready = 1'b1;

	// sequencing: clear sweep, then idle / update per request
	lph_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// bin addressing, length tracking and the counter table
	lph_dp #(
		.MAX_LEN       (MAX_LEN),
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.is_mapped    (is_mapped),
		.on_target    (on_target),
		.has_sequence (has_sequence),
		.seq_length   (seq_length),
		.map_position (map_position),
		.bin_length   (bin_length),
		.bin_position (bin_position),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_data     (transcript_length),
		.done         (done),
		.bin_count    (bin_count)
	);

endmodule
